[rtl/cba_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and microcode table of the chunked bitmap id allocator
package cba_pkg;

	localparam int IDX_W              = 12;
	localparam int TDATA_W            = 16;
	localparam int LIMIT_W            = 7;
	localparam int BITS_PER_CHUNK_DEF = 64;
	localparam int MAX_CHUNKS_DEF     = 64;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REFUSED  = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_PUSH     = 4'd0,
		S_IDLE     = 4'd1,
		S_DISPATCH = 4'd2,
		S_FCHECK   = 4'd3,
		S_FDIV     = 4'd4,
		S_FWRITE   = 4'd5,
		S_FERR     = 4'd6,
		S_AREAD    = 4'd7,
		S_ASCAN    = 4'd8,
		S_AFOUND   = 4'd9,
		S_AGROWCHK = 4'd10,
		S_AGROW    = 4'd11,
		S_ASET     = 4'd12,
		S_AREFUSE  = 4'd13
	} step_t;

	typedef enum logic [3:0] {
		U_NOP,
		U_PUSH,
		U_LOAD,
		U_DIV,
		U_REM,
		U_FREE_WR,
		U_FREE_ERR,
		U_SCAN,
		U_GROW,
		U_SET,
		U_REFUSE
	} uop_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_OUT_BLOCKED,
		C_NO_ACCEPT,
		C_IS_ALLOC,
		C_FREE_OUT,
		C_SCAN_MORE,
		C_FOUND,
		C_CANT_GROW
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		step_t target;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t uc;
		unique case (step)
			S_PUSH:     uc = '{U_PUSH,     C_OUT_BLOCKED, S_PUSH};
			S_IDLE:     uc = '{U_LOAD,     C_NO_ACCEPT,   S_IDLE};
			S_DISPATCH: uc = '{U_NOP,      C_IS_ALLOC,    S_AREAD};
			S_FCHECK:   uc = '{U_DIV,      C_FREE_OUT,    S_FERR};
			S_FDIV:     uc = '{U_REM,      C_NEVER,       S_FWRITE};
			S_FWRITE:   uc = '{U_FREE_WR,  C_ALWAYS,      S_PUSH};
			S_FERR:     uc = '{U_FREE_ERR, C_ALWAYS,      S_PUSH};
			S_AREAD:    uc = '{U_NOP,      C_NEVER,       S_IDLE};
			S_ASCAN:    uc = '{U_SCAN,     C_SCAN_MORE,   S_ASCAN};
			S_AFOUND:   uc = '{U_NOP,      C_FOUND,       S_ASET};
			S_AGROWCHK: uc = '{U_NOP,      C_CANT_GROW,   S_AREFUSE};
			S_AGROW:    uc = '{U_GROW,     C_ALWAYS,      S_PUSH};
			S_ASET:     uc = '{U_SET,      C_ALWAYS,      S_PUSH};
			S_AREFUSE:  uc = '{U_REFUSE,   C_ALWAYS,      S_PUSH};
			default:    uc = '{U_NOP,      C_ALWAYS,      S_IDLE};
		endcase
		return uc;
	endfunction

endpackage

[rtl/chunked_bitmap_id_allocator_top.sv]
`timescale 1ns / 1ps
// top level of the chunked bitmap id allocator
// One transaction at a time. A free passes through the dispatch and check steps;
// one within the chunks in use then goes on to the divide and write steps, one
// beyond them to its error step. A free's chunk comes from a reciprocal multiply
// and its bit offset from a multiply-subtract one step later. An alloc reads one
// bitmap word per cycle through the single read port of the bitmap ram, scanning
// the chunks in use until a clear bit turns up; it then sets that bit, or else
// grows the store by one chunk or refuses the request. A result waits in the
// output register while the next transaction is already accepted; the sequencer
// holds at its result step while an earlier result is still not taken. The ram
// needs no clearing pass: a chunk is written whole when it is enabled, and
// chunk 0 reads as clear until its first write.
module chunked_bitmap_id_allocator_top #(
	parameter int BITS_PER_CHUNK = cba_pkg::BITS_PER_CHUNK_DEF,
	parameter int MAX_CHUNKS     = cba_pkg::MAX_CHUNKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cba_pkg::LIMIT_W-1:0]  cfg_wdata,  // chunk_limit
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [cba_pkg::TDATA_W-1:0]  s_tdata,    // free_index[11:0], zero pad
	input  logic [0:0]                   s_tuser,    // command
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cba_pkg::TDATA_W-1:0]  m_tdata,    // index[11:0], zero pad
	output logic [1:0]                   m_tuser     // status
);
	import cba_pkg::*;

	localparam int BW     = $clog2(BITS_PER_CHUNK);
	localparam int AW     = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CIU_W  = $clog2(MAX_CHUNKS + 1);
	localparam int ID_W   = $clog2(MAX_CHUNKS * BITS_PER_CHUNK + 1);
	localparam int CMP_W  = (ID_W > IDX_W) ? ID_W : IDX_W;
	localparam int WIDE_W = CMP_W + 1;
	localparam int LIM_W  = (CIU_W > LIMIT_W) ? CIU_W : LIMIT_W;
	localparam int DIV_SH = IDX_W + BW;
	localparam int DIV_M  = ((1 << DIV_SH) + BITS_PER_CHUNK - 1) / BITS_PER_CHUNK;
	localparam int DIV_MW = $clog2(DIV_M + 1);
	localparam int PROD_W = IDX_W + DIV_MW;

	step_t                     step_q, step_d;
	ucode_t                    uc;
	logic                      cond_true;

	logic [LIMIT_W-1:0]        limit_q;
	logic [CIU_W-1:0]          ciu_q;
	logic [ID_W-1:0]           span_q;
	logic                      chunk0_ok_q;
	logic                      rd_zero_q;
	logic                      m_valid_q;
	status_t                   m_status_q;
	logic [IDX_W-1:0]          m_index_q;

	cmd_t                      cmd_q;
	logic [IDX_W-1:0]          fidx_q;
	logic [IDX_W-1:0]          rem_q;
	logic [CIU_W-1:0]          chunk_q;
	logic [ID_W-1:0]           base_q;
	logic                      found_q;
	logic [BW-1:0]             pos_q;
	logic [BITS_PER_CHUNK-1:0] word_q;
	status_t                   res_status_q;
	logic [IDX_W-1:0]          res_index_q;

	logic                      accept;
	logic                      push_ok;
	logic [BITS_PER_CHUNK-1:0] rdata;
	logic [BITS_PER_CHUNK-1:0] word_eff;
	logic                      word_full;
	logic [BW-1:0]             enc_pos;
	logic [CIU_W-1:0]          chunk_nxt;
	logic                      scan_more;
	logic                      free_out;
	logic                      can_grow;
	logic [LIM_W-1:0]          lim_eff;
	logic [CIU_W-1:0]          raddr_full;
	logic                      ram_we;
	logic [CIU_W-1:0]          waddr_full;
	logic [BITS_PER_CHUNK-1:0] ram_wdata;
	logic [WIDE_W-1:0]         id_set;
	logic [WIDE_W-1:0]         id_base;
	logic [PROD_W-1:0]         div_prod;
	logic [CIU_W-1:0]          div_quo;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (step_q == S_IDLE);
	assign push_ok   = !m_valid_q || m_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tuser   = m_status_q;
	assign m_tdata   = {{(TDATA_W - IDX_W){1'b0}}, m_index_q};

	assign word_eff  = (rd_zero_q && !chunk0_ok_q) ? '0 : rdata;
	assign word_full = &word_eff;
	assign chunk_nxt = CIU_W'(chunk_q + 1'b1);
	assign scan_more = word_full && (chunk_nxt < ciu_q);
	assign free_out  = CMP_W'(fidx_q) >= CMP_W'(span_q);
	assign lim_eff   = (LIM_W'(limit_q) > LIM_W'(MAX_CHUNKS)) ? LIM_W'(MAX_CHUNKS)
	                                                          : LIM_W'(limit_q);
	assign can_grow  = LIM_W'(ciu_q) < lim_eff;
	assign id_set    = WIDE_W'(base_q) + WIDE_W'(pos_q);
	assign id_base   = WIDE_W'(base_q);

	// chunk of the freed identifier by reciprocal multiply
	assign div_prod  = PROD_W'(fidx_q) * PROD_W'(DIV_M);
	assign div_quo   = CIU_W'(div_prod >> DIV_SH);

	always_comb begin
		enc_pos = '0;
		for (int i = BITS_PER_CHUNK - 1; i >= 0; i--) begin
			if (!word_eff[i]) begin
				enc_pos = BW'(i);
			end
		end
	end

	// next step
	always_comb begin
		uc = ucode_rom(step_q);
		case (uc.cond)
			C_NEVER:       cond_true = 1'b0;
			C_ALWAYS:      cond_true = 1'b1;
			C_OUT_BLOCKED: cond_true = !push_ok;
			C_NO_ACCEPT:   cond_true = !accept;
			C_IS_ALLOC:    cond_true = (cmd_q == CMD_ALLOC);
			C_FREE_OUT:    cond_true = free_out;
			C_SCAN_MORE:   cond_true = scan_more;
			C_FOUND:       cond_true = found_q;
			C_CANT_GROW:   cond_true = !can_grow;
			default:       cond_true = 1'b0;
		endcase
		step_d = cond_true ? uc.target : step_t'(step_q + 1'b1);
	end

	// datapath controls
	always_comb begin
		raddr_full = (uc.uop == U_SCAN) ? chunk_nxt : chunk_q;
		waddr_full = chunk_q;
		ram_we     = 1'b0;
		ram_wdata  = '0;
		case (uc.uop)
			U_FREE_WR: begin
				ram_we    = 1'b1;
				ram_wdata = word_eff & ~(BITS_PER_CHUNK'(1) << rem_q[BW-1:0]);
			end
			U_SET: begin
				ram_we    = 1'b1;
				ram_wdata = word_q | (BITS_PER_CHUNK'(1) << pos_q);
			end
			U_GROW: begin
				ram_we    = 1'b1;
				ram_wdata = BITS_PER_CHUNK'(1);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	cba_ram #(
		.WIDTH (BITS_PER_CHUNK),
		.DEPTH (MAX_CHUNKS),
		.AW    (AW)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_full[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (raddr_full[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= S_IDLE;
			limit_q     <= LIMIT_RESET;
			ciu_q       <= CIU_W'(1);
			span_q      <= ID_W'(BITS_PER_CHUNK);
			chunk0_ok_q <= 1'b0;
			rd_zero_q   <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			step_q    <= step_d;
			rd_zero_q <= (raddr_full == '0);
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (ram_we && waddr_full == '0) begin
				chunk0_ok_q <= 1'b1;
			end
			if (uc.uop == U_GROW) begin
				ciu_q  <= CIU_W'(ciu_q + 1'b1);
				span_q <= ID_W'(span_q + ID_W'(BITS_PER_CHUNK));
			end
			if (uc.uop == U_PUSH && push_ok) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uc.uop)
			U_PUSH: begin
				if (push_ok) begin
					m_status_q <= res_status_q;
					m_index_q  <= res_index_q;
				end
			end
			U_LOAD: begin
				if (accept) begin
					cmd_q   <= cmd_t'(s_tuser[0]);
					fidx_q  <= s_tdata[IDX_W-1:0];
					rem_q   <= s_tdata[IDX_W-1:0];
					chunk_q <= '0;
					base_q  <= '0;
					found_q <= 1'b0;
				end
			end
			U_DIV: begin
				chunk_q <= div_quo;
			end
			U_REM: begin
				rem_q <= IDX_W'(CMP_W'(fidx_q) - CMP_W'(chunk_q) * CMP_W'(BITS_PER_CHUNK));
			end
			U_FREE_WR: begin
				res_status_q <= ST_OK;
				res_index_q  <= fidx_q;
			end
			U_FREE_ERR: begin
				res_status_q <= ST_BAD_FREE;
				res_index_q  <= '0;
			end
			U_SCAN: begin
				if (!word_full) begin
					found_q <= 1'b1;
					pos_q   <= enc_pos;
					word_q  <= word_eff;
				end else begin
					chunk_q <= chunk_nxt;
					base_q  <= ID_W'(base_q + ID_W'(BITS_PER_CHUNK));
				end
			end
			U_GROW: begin
				res_status_q <= ST_OK;
				res_index_q  <= id_base[IDX_W-1:0];
			end
			U_SET: begin
				res_status_q <= ST_OK;
				res_index_q  <= id_set[IDX_W-1:0];
			end
			U_REFUSE: begin
				res_status_q <= ST_REFUSED;
				res_index_q  <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/cba_ram.sv]
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read
module cba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/cba_checker.sv]
`timescale 1ns / 1ps
// port-level assertions of the chunked bitmap id allocator and their bind
module cba_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [cba_pkg::TDATA_W-1:0] m_tdata,
	input logic [1:0]                  m_tuser
);
	import cba_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_err_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
		else $error("error result carries a nonzero index");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a transaction is in progress");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared right after the transaction was taken");

endmodule

bind chunked_bitmap_id_allocator_top cba_checker u_cba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[dv/chunked_bitmap_id_allocator_check.sv]
`timescale 1ns / 1ps
// checker of the id allocator: predicts each reply from the accepted commands and compares
module chunked_bitmap_id_allocator_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cba_pkg::LIMIT_W-1:0]  cfg_wdata,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [cba_pkg::TDATA_W-1:0]  s_tdata,    // free_index[11:0], zero pad
	input  logic [0:0]                   s_tuser,    // command
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [cba_pkg::TDATA_W-1:0]  m_tdata,    // index[11:0], zero pad
	input  logic [1:0]                   m_tuser,    // status
	output int                           errors,
	output int                           pending
);
	import cba_pkg::*;

	localparam int CHUNK_BITS = BITS_PER_CHUNK_DEF;
	localparam int CHUNK_CNT  = MAX_CHUNKS_DEF;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] index;
	} id_reply_t;

	logic [CHUNK_BITS-1:0] id_map [CHUNK_CNT];
	int                    chunks_open;
	logic [LIMIT_W-1:0]    limit_r;
	id_reply_t             due_replies[$];
	int                    fail_cnt;

	function automatic id_reply_t next_reply(input cmd_t cmd, input logic [IDX_W-1:0] idx);
		id_reply_t r;
		int        c;
		int        b;
		int        cap;
		r = '{ST_OK, '0};
		if (cmd == CMD_FREE) begin
			if (int'(idx) < chunks_open * CHUNK_BITS) begin
				id_map[int'(idx) / CHUNK_BITS][int'(idx) % CHUNK_BITS] = 1'b0;
				r.index = idx;
			end else begin
				r.status = ST_BAD_FREE;
			end
			return r;
		end
		for (c = 0; c < chunks_open; c++) begin
			if (id_map[c] != '1) begin
				b = 0;
				while (id_map[c][b])
					b++;
				id_map[c][b] = 1'b1;
				r.index = IDX_W'(c * CHUNK_BITS + b);
				return r;
			end
		end
		// limit saturates at the number of chunks the store holds
		cap = (int'(limit_r) > CHUNK_CNT) ? CHUNK_CNT : int'(limit_r);
		if (chunks_open < cap) begin
			id_map[chunks_open] = CHUNK_BITS'(1);
			r.index = IDX_W'(chunks_open * CHUNK_BITS);
			chunks_open++;
			return r;
		end
		r.status = ST_REFUSED;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		id_reply_t want;
		id_reply_t got;
		if (!arst_n) begin
			for (int c = 0; c < CHUNK_CNT; c++)
				id_map[c] = '0;
			chunks_open = 1;
			limit_r = LIMIT_RESET;
			due_replies.delete();
			fail_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				limit_r = cfg_wdata;
			if (s_tvalid && s_tready)
				due_replies.push_back(next_reply(cmd_t'(s_tuser), s_tdata[IDX_W-1:0]));
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.index = m_tdata[IDX_W-1:0];
				if (due_replies.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("unexpected reply: status %0d index %0d",
							m_tuser, got.index);
				end else begin
					want = due_replies.pop_front();
					if (got.status != want.status || got.index != want.index) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("reply mismatch: expected status %0d index %0d, got status %0d index %0d",
								want.status, want.index, m_tuser, got.index);
					end
				end
			end
			errors <= fail_cnt;
			pending <= due_replies.size();
		end
	end

endmodule

[dv/chunked_bitmap_id_allocator_top_test.sv]
`timescale 1ns / 1ps
// stimulus, idle patterns, watchdog and verdict for the chunked bitmap id allocator
module chunked_bitmap_id_allocator_top_test;
	import cba_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [LIMIT_W-1:0]   cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic [0:0]           s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [1:0]           m_tuser;
	int                   errors;
	int                   pending;
	int                   send_idle_pct = 0;
	int                   rcv_stall_pct = 0;
	int                   quiet_cycles = 0;
	int                   cur_limit = 64;

	chunked_bitmap_id_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	chunked_bitmap_id_allocator_check check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99, 0) >= rcv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("chunked_bitmap_id_allocator_top_test NOT OK");
			$finish;
		end
	end

	task automatic issue(input cmd_t cmd, input logic [IDX_W-1:0] id);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= TDATA_W'(id);
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic drain_all();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic set_limit(input logic [LIMIT_W-1:0] v);
		drain_all();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_limit = int'(v);
	endtask

	task automatic set_idle(input int send_pct, input int rcv_pct);
		send_idle_pct = send_pct;
		rcv_stall_pct = rcv_pct;
	endtask

	task automatic random_burst(input int n);
		int k;
		int pick;
		int span;
		span = (cur_limit < 1) ? 1 : ((cur_limit > 64) ? 64 : cur_limit);
		span = span * BITS_PER_CHUNK_DEF;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(99, 0);
			if (pick < 55)
				issue(CMD_ALLOC, IDX_W'($urandom));
			else if (pick < 85)
				issue(CMD_FREE, IDX_W'($urandom_range(span - 1, 0)));
			else if (pick < 92)
				issue(CMD_FREE, IDX_W'(span - 1 + $urandom_range(1, 0)));
			else
				issue(CMD_FREE, IDX_W'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// frees on a fresh store, in and beyond the first chunk, then allocs and a free
		issue(CMD_FREE, 12'd0);
		issue(CMD_FREE, 12'd63);
		issue(CMD_FREE, 12'd64);
		issue(CMD_FREE, 12'hFFF);
		issue(CMD_FREE, 12'h555);
		issue(CMD_FREE, 12'hAAA);
		issue(CMD_ALLOC, 12'hFFF);
		issue(CMD_ALLOC, 12'h000);
		issue(CMD_FREE, 12'd0);
		issue(CMD_ALLOC, 12'h5A5);

		// no growth allowed: fill chunk 0, then refusals; then growth to a second chunk and frees around it
		set_limit(7'd0);
		repeat (62) issue(CMD_ALLOC, 12'd0);
		issue(CMD_ALLOC, 12'd0);
		set_limit(7'd1);
		issue(CMD_ALLOC, 12'd0);
		set_limit(7'd2);
		issue(CMD_ALLOC, 12'd0);
		issue(CMD_FREE, 12'd127);
		issue(CMD_FREE, 12'd128);
		issue(CMD_FREE, 12'd64);
		issue(CMD_ALLOC, 12'd0);

		// random traffic under small limits and every idle pattern
		set_idle(0, 0);
		set_limit(7'd2);
		random_burst(150);
		set_idle(81, 0);
		set_limit(7'd3);
		random_burst(150);
		set_idle(0, 81);
		set_limit(7'd0);
		random_burst(150);
		set_idle(31, 31);
		set_limit(7'd6);
		random_burst(150);
		set_idle(0, 0);
		set_limit(LIMIT_W'($urandom_range(12, 4)));
		random_burst(80);

		// limit above the store size: allocs with room to grow past the earlier limits
		set_idle(31, 31);
		set_limit(7'd127);
		repeat (200) issue(CMD_ALLOC, IDX_W'($urandom));
		set_idle(0, 81);
		random_burst(80);
		set_idle(81, 0);
		random_burst(60);

		// limit set back to 64, then lowered below the chunks in use
		set_idle(0, 0);
		set_limit(7'd64);
		random_burst(40);
		set_idle(31, 31);
		set_limit(7'd1);
		random_burst(60);
		issue(CMD_FREE, 12'hFFF);
		issue(CMD_ALLOC, 12'd0);
		issue(CMD_ALLOC, 12'd0);

		drain_all();
		repeat (16) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("chunked_bitmap_id_allocator_top_test OK");
		else
			$display("chunked_bitmap_id_allocator_top_test NOT OK");
		$finish;
	end

endmodule
